// ===== rtl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared widths, register codes and pipeline payload types of the ray to
// circle distance unit.
// ----------------------------------------------------------------------------
package rcd_pkg;

    // port widths
    localparam int POS_W     = 32;            // Q16.16 positions
    localparam int DIR_W     = 18;            // Q1.16 direction
    localparam int RAD_W     = 31;            // unsigned Q15.16 radius
    localparam int DIST_W    = 32;            // unsigned Q16.16 distance
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // internal widths
    localparam int OFS_W      = POS_W + 1;        // point - center
    localparam int PROD_W     = OFS_W + DIR_W;    // x*dx
    localparam int K_W        = PROD_W + 1;       // x*dx + y*dy, frac 32
    localparam int AK_W       = K_W - 1;          // |k|
    localparam int XSQ_FULL_W = 2 * OFS_W;        // signed x*x
    localparam int SQ_W       = XSQ_FULL_W - 1;   // x*x is never negative
    localparam int S2_W       = SQ_W + 1;         // x*x + y*y, frac 32
    localparam int R2_W       = 2 * RAD_W;        // radius^2, frac 32
    localparam int AKL_W      = 32;               // low slice of |k|
    localparam int AKH_W      = AK_W - AKL_W;     // high slice of |k|
    localparam int HH_W       = 2 * AKH_W;
    localparam int HL_W       = AKH_W + AKL_W;
    localparam int LL_W       = 2 * AKL_W;
    localparam int SQ_SHIFT   = 32;               // frac 32 -> frac 64
    localparam int LHS_W      = 101;              // k^2 + r^2, frac 64
    localparam int DET_W      = LHS_W + 1;        // with sign
    localparam int ROOT_W     = 52;               // root bits, frac 32
    localparam int REM_W      = 104;              // root remainder
    localparam int VAL_W      = ROOT_W + 1;       // |k| +/- root
    localparam int FRAC_SHIFT = 16;               // frac 32 -> frac 16

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

    typedef struct packed {
        logic coin;       // origin on the circle
        logic k_neg;      // k < 0, ray heading toward the center
        logic k_zero;     // k == 0
        logic c_neg;      // origin inside the circle
        logic det_neg;    // discriminant below zero
    } rcd_flags_t;

    typedef struct packed {
        logic [AK_W-1:0] ak;
        rcd_flags_t      flags;
    } rcd_side_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              miss;
    } rcd_result_t;

endpackage

// ===== rtl/rcd_disc.sv =====
// ----------------------------------------------------------------------------
// rcd_disc
// Eight stage front end: offset to the center, k, |offset|^2, radius^2 and
// the discriminant k^2 - c at 64 fraction bits.
// ----------------------------------------------------------------------------
module rcd_disc (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [rcd_pkg::POS_W-1:0]    point_x,
    input  logic signed [rcd_pkg::POS_W-1:0]    point_y,
    input  logic signed [rcd_pkg::DIR_W-1:0]    dir_x,
    input  logic signed [rcd_pkg::DIR_W-1:0]    dir_y,
    input  logic                                coincident,
    input  logic signed [rcd_pkg::POS_W-1:0]    center_x,
    input  logic signed [rcd_pkg::POS_W-1:0]    center_y,
    input  logic        [rcd_pkg::RAD_W-1:0]    radius,
    output logic                                out_valid,
    output logic        [rcd_pkg::LHS_W-1:0]    det,
    output rcd_pkg::rcd_side_t                  out_side
);
    import rcd_pkg::*;

    localparam int NSTG = 8;

    logic [NSTG-1:0] vld_reg;

    // stage 1
    logic signed [OFS_W-1:0]  x_reg, y_reg;
    logic signed [DIR_W-1:0]  dx_reg, dy_reg;
    logic                     coin1_reg;
    // stage 2
    logic signed [PROD_W-1:0] px_reg, py_reg;
    logic [SQ_W-1:0]          xsq_reg, ysq_reg;
    logic [R2_W-1:0]          r2_2_reg;
    logic                     coin2_reg;
    // stage 3
    logic signed [K_W-1:0]    k_reg;
    logic [S2_W-1:0]          s2_3_reg;
    logic [R2_W-1:0]          r2_3_reg;
    logic                     coin3_reg;
    // stage 4
    logic [AK_W-1:0]          ak4_reg;
    rcd_flags_t               flags4_reg;
    logic [S2_W-1:0]          s2_4_reg;
    logic [R2_W-1:0]          r2_4_reg;
    // stage 5
    logic [HH_W-1:0]          pp_hh_reg;
    logic [HL_W-1:0]          pp_hl_reg;
    logic [LL_W-1:0]          pp_ll_reg;
    logic [AK_W-1:0]          ak5_reg;
    rcd_flags_t               flags5_reg;
    logic [S2_W-1:0]          s2_5_reg;
    logic [R2_W-1:0]          r2_5_reg;
    // stage 6
    logic [LHS_W-1:0]         aksq_reg;
    logic [AK_W-1:0]          ak6_reg;
    rcd_flags_t               flags6_reg;
    logic [S2_W-1:0]          s2_6_reg;
    logic [R2_W-1:0]          r2_6_reg;
    // stage 7
    logic [LHS_W-1:0]         lhs_reg;
    logic [AK_W-1:0]          ak7_reg;
    rcd_flags_t               flags7_reg;
    logic [S2_W-1:0]          s2_7_reg;
    // stage 8
    logic [LHS_W-1:0]         det_reg;
    rcd_side_t                side8_reg;

    // next values
    logic signed [OFS_W-1:0]      x_next, y_next;
    logic signed [PROD_W-1:0]     px_next, py_next;
    logic signed [XSQ_FULL_W-1:0] xsq_full, ysq_full;
    logic [R2_W-1:0]              r2_next;
    logic signed [K_W-1:0]        k_next, k_inv;
    logic [S2_W-1:0]              s2_next;
    logic [AK_W-1:0]              ak_next;
    rcd_flags_t                   flags4_next, flags8_next;
    logic [AKH_W-1:0]             akh;
    logic [AKL_W-1:0]             akl;
    logic [HH_W-1:0]              pp_hh_next;
    logic [HL_W-1:0]              pp_hl_next;
    logic [LL_W-1:0]              pp_ll_next;
    logic [LHS_W-1:0]             aksq_next, lhs_next;
    logic signed [DET_W-1:0]      diff_next;

    always_comb
    begin
        x_next     = OFS_W'(point_x) - OFS_W'(center_x);
        y_next     = OFS_W'(point_y) - OFS_W'(center_y);

        px_next    = PROD_W'(x_reg) * PROD_W'(dx_reg);
        py_next    = PROD_W'(y_reg) * PROD_W'(dy_reg);
        xsq_full   = XSQ_FULL_W'(x_reg) * XSQ_FULL_W'(x_reg);
        ysq_full   = XSQ_FULL_W'(y_reg) * XSQ_FULL_W'(y_reg);
        r2_next    = R2_W'(radius) * R2_W'(radius);

        k_next     = K_W'(px_reg) + K_W'(py_reg);
        s2_next    = S2_W'(xsq_reg) + S2_W'(ysq_reg);

        k_inv      = -k_reg;
        ak_next    = k_reg[K_W-1] ? k_inv[AK_W-1:0] : k_reg[AK_W-1:0];
        flags4_next.coin    = coin3_reg;
        flags4_next.k_neg   = k_reg[K_W-1];
        flags4_next.k_zero  = (k_reg == '0);
        flags4_next.c_neg   = (s2_3_reg < S2_W'(r2_3_reg));
        flags4_next.det_neg = 1'b0;

        // |k|^2 from three partial products
        akh        = ak4_reg[AK_W-1:AKL_W];
        akl        = ak4_reg[AKL_W-1:0];
        pp_hh_next = HH_W'(akh) * HH_W'(akh);
        pp_hl_next = HL_W'(akh) * HL_W'(akl);
        pp_ll_next = LL_W'(akl) * LL_W'(akl);

        aksq_next  = (LHS_W'(pp_hh_reg) << (2 * AKL_W))
                   + (LHS_W'(pp_hl_reg) << (AKL_W + 1))
                   + LHS_W'(pp_ll_reg);

        lhs_next   = aksq_reg + (LHS_W'(r2_6_reg) << SQ_SHIFT);

        diff_next  = DET_W'(lhs_reg) - (DET_W'(s2_7_reg) << SQ_SHIFT);
        flags8_next         = flags7_reg;
        flags8_next.det_neg = diff_next[DET_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            dx_reg     <= dir_x;
            dy_reg     <= dir_y;
            coin1_reg  <= coincident;

            px_reg     <= px_next;
            py_reg     <= py_next;
            xsq_reg    <= xsq_full[SQ_W-1:0];
            ysq_reg    <= ysq_full[SQ_W-1:0];
            r2_2_reg   <= r2_next;
            coin2_reg  <= coin1_reg;

            k_reg      <= k_next;
            s2_3_reg   <= s2_next;
            r2_3_reg   <= r2_2_reg;
            coin3_reg  <= coin2_reg;

            ak4_reg    <= ak_next;
            flags4_reg <= flags4_next;
            s2_4_reg   <= s2_3_reg;
            r2_4_reg   <= r2_3_reg;

            pp_hh_reg  <= pp_hh_next;
            pp_hl_reg  <= pp_hl_next;
            pp_ll_reg  <= pp_ll_next;
            ak5_reg    <= ak4_reg;
            flags5_reg <= flags4_reg;
            s2_5_reg   <= s2_4_reg;
            r2_5_reg   <= r2_4_reg;

            aksq_reg   <= aksq_next;
            ak6_reg    <= ak5_reg;
            flags6_reg <= flags5_reg;
            s2_6_reg   <= s2_5_reg;
            r2_6_reg   <= r2_5_reg;

            lhs_reg    <= lhs_next;
            ak7_reg    <= ak6_reg;
            flags7_reg <= flags6_reg;
            s2_7_reg   <= s2_6_reg;

            det_reg          <= diff_next[LHS_W-1:0];
            side8_reg.ak     <= ak7_reg;
            side8_reg.flags  <= flags8_next;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign det       = det_reg;
    assign out_side  = side8_reg;

endmodule

// ===== rtl/rcd_sqrt.sv =====
// ----------------------------------------------------------------------------
// rcd_sqrt
// Pipelined floor square root, one result bit per stage, most significant
// first. Sideband travels alongside.
// ----------------------------------------------------------------------------
module rcd_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [rcd_pkg::LHS_W-1:0]        det,
    input  rcd_pkg::rcd_side_t               in_side,
    output logic                             out_valid,
    output logic [rcd_pkg::ROOT_W-1:0]       root,
    output rcd_pkg::rcd_side_t               out_side
);
    import rcd_pkg::*;

    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-2];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    rcd_side_t         side_reg [0:ROOT_W-1];
    logic              vld_reg  [0:ROOT_W-1];

    genvar g;
    for (g = 0; g < ROOT_W; g++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - g;

        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  trial;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_next;
        rcd_side_t         side_in;
        logic              vld_in;
        logic              fits;

        if (g == 0)
        begin : g_first
            assign rem_in  = REM_W'(det);
            assign root_in = '0;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign side_in = side_reg[g-1];
            assign vld_in  = vld_reg[g-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        always_comb
        begin
            trial     = (REM_W'(root_in) << (B + 1)) | (REM_W'(1) << (2 * B));
            fits      = (rem_in >= trial);
            root_next = root_in | (ROOT_W'(fits) << B);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (en)
                vld_reg[g] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[g] <= root_next;
                side_reg[g] <= side_in;
            end
        end

        if (g < ROOT_W - 1)
        begin : g_rem
            logic [REM_W-1:0] rem_next;

            assign rem_next = fits ? (rem_in - trial) : rem_in;

            always_ff @(posedge clk)
            begin
                if (en)
                    rem_reg[g] <= rem_next;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== rtl/rcd_sel.sv =====
// ----------------------------------------------------------------------------
// rcd_sel
// Root selection: near or far root by case, miss decision and saturation
// of the Q16.16 distance.
// ----------------------------------------------------------------------------
module rcd_sel (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [rcd_pkg::ROOT_W-1:0]   root,
    input  rcd_pkg::rcd_side_t           in_side,
    output logic                         out_valid,
    output rcd_pkg::rcd_result_t         result
);
    import rcd_pkg::*;

    logic        vld_reg;
    rcd_result_t res_reg;
    rcd_result_t res_next;

    logic [VAL_W-1:0] ak_ext, root_ext, sum, ak_m_root, root_m_ak, val;
    logic             ak_ge, root_ge, hit, over;
    rcd_flags_t       f;

    always_comb
    begin
        ak_ext    = VAL_W'(in_side.ak);
        root_ext  = VAL_W'(root);
        sum       = ak_ext + root_ext;
        ak_m_root = ak_ext - root_ext;
        root_m_ak = root_ext - ak_ext;
        ak_ge     = (ak_ext >= root_ext);
        root_ge   = (root_ext >= ak_ext);
        f         = in_side.flags;
        val       = '0;
        hit       = 1'b0;

        if (f.det_neg)
        begin
            hit = 1'b0;
        end
        else if (f.coin)
        begin
            // on the surface: only an incoming ray reaches the far side
            hit = f.k_neg;
            val = sum;
        end
        else if (f.c_neg)
        begin
            // inside: far root, clamped at zero
            hit = 1'b1;
            if (f.k_neg)
                val = sum;
            else if (root_ge)
                val = root_m_ak;
            else
                val = '0;
        end
        else
        begin
            // outside: near root, must lie ahead
            hit = (f.k_neg | f.k_zero) & ak_ge;
            val = ak_m_root;
        end

        over              = |val[VAL_W-1:DIST_W+FRAC_SHIFT];
        res_next.miss     = !hit | over;
        res_next.distance = res_next.miss ? '1 : val[DIST_W+FRAC_SHIFT-1:FRAC_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = vld_reg;
    assign result    = res_reg;

endmodule

// ===== rtl/rcd_skid.sv =====
// ----------------------------------------------------------------------------
// rcd_skid
// Output register with one skid entry. Upstream ready comes from a flop,
// so the pipeline keeps moving while a beat waits on the output.
// ----------------------------------------------------------------------------
module rcd_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  rcd_pkg::rcd_result_t   up_data,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output rcd_pkg::rcd_result_t   dn_data
);
    import rcd_pkg::*;

    logic        out_vld_reg, out_vld_next;
    logic        skd_vld_reg, skd_vld_next;
    rcd_result_t out_data_reg, out_data_next;
    rcd_result_t skd_data_reg, skd_data_next;
    logic        take_up, take_dn;

    always_comb
    begin
        take_up       = up_valid & ~skd_vld_reg;
        take_dn       = out_vld_reg & dn_ready;
        out_vld_next  = out_vld_reg;
        skd_vld_next  = skd_vld_reg;
        out_data_next = out_data_reg;
        skd_data_next = skd_data_reg;

        if (!out_vld_reg || take_dn)
        begin
            // output slot frees: refill from skid first
            out_vld_next = skd_vld_reg | take_up;
            skd_vld_next = 1'b0;
            if (skd_vld_reg)
                out_data_next = skd_data_reg;
            else
                out_data_next = up_data;
        end
        else if (take_up)
        begin
            skd_vld_next  = 1'b1;
            skd_data_next = up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            skd_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            skd_vld_reg <= skd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skd_data_reg <= skd_data_next;
    end

    assign up_ready = ~skd_vld_reg;
    assign dn_valid = out_vld_reg;
    assign dn_data  = out_data_reg;

endmodule

// ===== rtl/ray_circle_distance_unit.sv =====
// ----------------------------------------------------------------------------
// ray_circle_distance_unit
// Distance along a ray to the boundary of a configured circle, or a miss.
//
//   channel   handshake               payload
//   in        in_valid / in_ready     point_x, point_y, dir_x, dir_y, coincident
//   out       out_valid / out_ready   distance, miss
//   cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One beat in per cycle while the stages are not held. From input to output register:
// 8 discriminant stages, 52 square root stages (one root bit per stage), root selection
// and the output register. The square root pipe sets the depth.
// Reset clears valids and config registers. All stages advance together;
// they hold only when both the output register and its skid entry are full.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module ray_circle_distance_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [rcd_pkg::POS_W-1:0]     point_x,
    input  logic signed [rcd_pkg::POS_W-1:0]     point_y,
    input  logic signed [rcd_pkg::DIR_W-1:0]     dir_x,
    input  logic signed [rcd_pkg::DIR_W-1:0]     dir_y,
    input  logic                                 coincident,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [rcd_pkg::DIST_W-1:0]    distance,
    output logic                                 miss,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [rcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [rcd_pkg::CFG_DAT_W-1:0] cfg_data
);
    import rcd_pkg::*;

    logic signed [POS_W-1:0] center_x_reg;
    logic signed [POS_W-1:0] center_y_reg;
    logic        [RAD_W-1:0] radius_reg;

    logic             pipe_en;
    logic             disc_valid;
    logic [LHS_W-1:0] disc_det;
    rcd_side_t        disc_side;
    logic             sqrt_valid;
    logic [ROOT_W-1:0] sqrt_root;
    rcd_side_t        sqrt_side;
    logic             sel_valid;
    rcd_result_t      sel_result;
    rcd_result_t      out_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data[POS_W-1:0];
                CFG_CENTER_Y: center_y_reg <= cfg_data[POS_W-1:0];
                CFG_RADIUS:   radius_reg   <= cfg_data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    assign in_ready = pipe_en;

    rcd_disc u_disc (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_valid   (in_valid),
        .point_x    (point_x),
        .point_y    (point_y),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .coincident (coincident),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .radius     (radius_reg),
        .out_valid  (disc_valid),
        .det        (disc_det),
        .out_side   (disc_side)
    );

    rcd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (disc_valid),
        .det       (disc_det),
        .in_side   (disc_side),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .out_side  (sqrt_side)
    );

    rcd_sel u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (sqrt_valid),
        .root      (sqrt_root),
        .in_side   (sqrt_side),
        .out_valid (sel_valid),
        .result    (sel_result)
    );

    rcd_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sel_valid),
        .up_ready (pipe_en),
        .up_data  (sel_result),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .dn_data  (out_result)
    );

    assign distance = out_result.distance;
    assign miss     = out_result.miss;

endmodule
